### hdl/ctf_pkg.sv
// types and codes shared by the connection table block
`timescale 1ns / 1ps
`default_nettype none
package ctf_pkg;

  localparam logic [2:0] MODE_OPEN    = 3'd0;
  localparam logic [2:0] MODE_LISTEN  = 3'd1;
  localparam logic [2:0] MODE_CLOSE   = 3'd2;
  localparam logic [2:0] MODE_SEGMENT = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  localparam logic [1:0] SEG_SYN = 2'd0;
  localparam logic [1:0] SEG_FIN = 2'd1;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_FULL        = 3'd1;
  localparam logic [2:0] STATUS_BAD_SOCK    = 3'd2;
  localparam logic [2:0] STATUS_WRONG_STATE = 3'd3;
  localparam logic [2:0] STATUS_IGNORED     = 3'd4;

  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_SYNACK = 2'd1;
  localparam logic [1:0] REPLY_FINACK = 2'd2;

  typedef enum logic [1:0] {
    ST_CLOSED,
    ST_LISTENING,
    ST_CONNECTED,
    ST_CLOSEWAIT
  } conn_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    conn_state_t st;
    logic [15:0] wait_cnt;
    logic [15:0] server;
    logic [15:0] client;
  } entry_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  sock_id;
    logic [15:0] local_port;
    logic [1:0]  seg_kind;
    logic [15:0] seg_sport;
    logic [15:0] seg_dport;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  sock_out;
    logic [1:0]  reply_type;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic        connected;
  } rsp_t;

endpackage
`default_nettype wire

### hdl/ctf_intf.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ctf_cmd_if;
  logic          valid;
  logic          ready;
  ctf_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctf_rsp_if;
  logic          valid;
  logic          ready;
  ctf_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/connection_table_fsm_top.sv
// connection table: per-entry memory, lookup scan and tick countdown
// listen, close, unknown modes, other segment kinds: go from accept straight to the finish state
// next request can be taken in the same cycle the result is presented; finish waits for a free output
// open: walks the valid bits one per cycle, stopping at the first free entry
// syn/fin segment: walks all entries through the one read port, then the drain and pick states
// tick: walks all entries with read-modify-write, then the drain state
// reset clears valid bits, state machine and output; ticks resets to 1; no memory sweep
`timescale 1ns / 1ps
`default_nettype none
module connection_table_fsm_top #(
  parameter int CONNECTIONS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ctf_cmd_if.sink   cmd,
  ctf_rsp_if.source rsp,
  ctf_cfg_if.sink   cfg
);

  localparam int IW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  ctf_pkg::fsm_state_t state, state_next;
  ctf_pkg::cmd_t       req;
  ctf_pkg::rsp_t       rsp_item, res;
  logic                rsp_valid;

  logic [15:0]            ticks;
  logic [CONNECTIONS-1:0] entry_valid;
  ctf_pkg::entry_t        mem [CONNECTIONS];
  ctf_pkg::entry_t        mem_q, mem_wd;
  logic [IW-1:0]          mem_ra, mem_wa;
  logic                   mem_we;

  logic [IW-1:0] scan_idx, rd_idx, tgt, pair_idx, srv_idx, pick_idx, sid_idx;
  logic          rd_pend, hit, pair_found, srv_found, pick_hit;
  logic          accept, scan_last, out_free, fin, sid_ok, pair_m, srv_m, rd_v;
  logic          valid_set, valid_clr;

  assign accept    = cmd.valid && cmd.ready;
  assign scan_last = (scan_idx == IW'(CONNECTIONS - 1));
  assign out_free  = !rsp_valid || rsp.ready;
  assign fin       = (state == ctf_pkg::S_FINISH) && out_free;
  assign sid_idx   = IW'(cmd.data.sock_id);
  assign sid_ok    = (int'(cmd.data.sock_id) < CONNECTIONS);
  assign rd_v      = entry_valid[rd_idx];
  assign srv_m     = rd_v && (mem_q.server == req.seg_dport);
  assign pair_m    = srv_m && (mem_q.client == req.seg_sport);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_item;

  always_comb begin
    if (pair_found) begin
      pick_idx = pair_idx;
      pick_hit = 1'b1;
    end else if (req.seg_kind == ctf_pkg::SEG_SYN && srv_found) begin
      pick_idx = srv_idx;
      pick_hit = 1'b1;
    end else begin
      pick_idx = '0;
      pick_hit = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctf_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd.data.mode)
            ctf_pkg::MODE_OPEN, ctf_pkg::MODE_TICK: state_next = ctf_pkg::S_SCAN;
            ctf_pkg::MODE_SEGMENT: begin
              if (cmd.data.seg_kind == ctf_pkg::SEG_SYN ||
                  cmd.data.seg_kind == ctf_pkg::SEG_FIN) begin
                state_next = ctf_pkg::S_SCAN;
              end else begin
                state_next = ctf_pkg::S_FINISH;
              end
            end
            default: state_next = ctf_pkg::S_FINISH;
          endcase
        end
      end
      ctf_pkg::S_SCAN: begin
        if (req.mode == ctf_pkg::MODE_OPEN) begin
          if (!entry_valid[scan_idx] || scan_last) state_next = ctf_pkg::S_FINISH;
        end else if (scan_last) begin
          state_next = ctf_pkg::S_DRAIN;
        end
      end
      ctf_pkg::S_DRAIN: begin
        state_next = (req.mode == ctf_pkg::MODE_SEGMENT) ? ctf_pkg::S_PICK
                                                         : ctf_pkg::S_FINISH;
      end
      ctf_pkg::S_PICK: state_next = ctf_pkg::S_FINISH;
      ctf_pkg::S_FINISH: begin
        if (out_free) state_next = ctf_pkg::S_IDLE;
      end
      default: state_next = ctf_pkg::S_IDLE;
    endcase
  end

  // outputs: read address, writes and the result
  always_comb begin
    cmd.ready = (state == ctf_pkg::S_IDLE);
    unique case (state)
      ctf_pkg::S_IDLE: mem_ra = sid_idx;
      ctf_pkg::S_SCAN: mem_ra = scan_idx;
      ctf_pkg::S_PICK: mem_ra = pick_idx;
      default:         mem_ra = tgt;
    endcase

    mem_we    = 1'b0;
    mem_wa    = tgt;
    mem_wd    = mem_q;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    res       = '0;
    res.status = ctf_pkg::STATUS_OK;

    // tick countdown, one entry behind the read
    if (rd_pend && req.mode == ctf_pkg::MODE_TICK && rd_v &&
        mem_q.st == ctf_pkg::ST_CLOSEWAIT) begin
      mem_we = 1'b1;
      mem_wa = rd_idx;
      if (mem_q.wait_cnt > 16'd1) begin
        mem_wd.wait_cnt = mem_q.wait_cnt - 16'd1;
      end else begin
        mem_wd.wait_cnt = '0;
        mem_wd.st       = ctf_pkg::ST_CLOSED;
      end
    end

    if (state == ctf_pkg::S_FINISH) begin
      unique case (req.mode)
        ctf_pkg::MODE_OPEN: begin
          if (hit) begin
            mem_we          = fin;
            mem_wd.st       = ctf_pkg::ST_CLOSED;
            mem_wd.wait_cnt = '0;
            mem_wd.server   = req.local_port;
            mem_wd.client   = '0;
            valid_set       = fin;
            res.sock_out    = 4'(tgt);
          end else begin
            res.status = ctf_pkg::STATUS_FULL;
          end
        end
        ctf_pkg::MODE_LISTEN: begin
          if (hit) begin
            mem_we          = fin;
            mem_wd.st       = ctf_pkg::ST_LISTENING;
            mem_wd.wait_cnt = '0;
            res.sock_out    = 4'(tgt);
          end else begin
            res.status = ctf_pkg::STATUS_BAD_SOCK;
          end
        end
        ctf_pkg::MODE_CLOSE: begin
          if (!hit) begin
            res.status = ctf_pkg::STATUS_BAD_SOCK;
          end else begin
            res.sock_out = 4'(tgt);
            if (mem_q.st == ctf_pkg::ST_CLOSED) begin
              valid_clr = fin;
            end else begin
              res.status = ctf_pkg::STATUS_WRONG_STATE;
            end
          end
        end
        ctf_pkg::MODE_SEGMENT: begin
          res.status = ctf_pkg::STATUS_IGNORED;
          if (hit) begin
            res.sock_out = 4'(tgt);
            if (req.seg_kind == ctf_pkg::SEG_SYN) begin
              if (mem_q.st == ctf_pkg::ST_LISTENING) begin
                mem_we         = fin;
                mem_wd.st      = ctf_pkg::ST_CONNECTED;
                mem_wd.client  = req.seg_sport;
                res.connected  = 1'b1;
                res.reply_type = ctf_pkg::REPLY_SYNACK;
              end else if (mem_q.st == ctf_pkg::ST_CONNECTED) begin
                res.reply_type = ctf_pkg::REPLY_SYNACK;
              end
            end else begin
              if (mem_q.st == ctf_pkg::ST_CONNECTED) begin
                mem_we          = fin;
                mem_wd.st       = ctf_pkg::ST_CLOSEWAIT;
                mem_wd.wait_cnt = (ticks != 16'd0) ? ticks : 16'd1;
                res.reply_type  = ctf_pkg::REPLY_FINACK;
              end else if (mem_q.st == ctf_pkg::ST_CLOSEWAIT) begin
                res.reply_type = ctf_pkg::REPLY_FINACK;
              end
            end
            if (res.reply_type != ctf_pkg::REPLY_NONE) begin
              res.status          = ctf_pkg::STATUS_OK;
              res.reply_src_port  = mem_wd.server;
              res.reply_dest_port = mem_wd.client;
            end
          end
        end
        ctf_pkg::MODE_TICK: res.status = ctf_pkg::STATUS_OK;
        default: res.status = ctf_pkg::STATUS_IGNORED;
      endcase
    end
  end

  // entry memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ctf_pkg::S_IDLE;
      rsp_valid   <= 1'b0;
      entry_valid <= '0;
      ticks       <= 16'd1;
      rd_pend     <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ctf_pkg::S_SCAN);
      if (cfg.valid && cfg.ready) ticks <= cfg.data;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (valid_set) entry_valid[tgt] <= 1'b1;
      if (valid_clr) entry_valid[tgt] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (fin) rsp_item <= res;
    if (accept) begin
      req        <= cmd.data;
      scan_idx   <= '0;
      tgt        <= sid_idx;
      pair_found <= 1'b0;
      srv_found  <= 1'b0;
      hit        <= (cmd.data.mode == ctf_pkg::MODE_LISTEN ||
                     cmd.data.mode == ctf_pkg::MODE_CLOSE) &&
                    sid_ok && entry_valid[sid_idx];
    end
    if (state == ctf_pkg::S_SCAN) begin
      if (!scan_last) scan_idx <= scan_idx + IW'(1);
      if (req.mode == ctf_pkg::MODE_OPEN && !entry_valid[scan_idx]) begin
        tgt <= scan_idx;
        hit <= 1'b1;
      end
    end
    // first exact pair and first server-port match
    if (rd_pend && req.mode == ctf_pkg::MODE_SEGMENT) begin
      if (pair_m && !pair_found) begin
        pair_found <= 1'b1;
        pair_idx   <= rd_idx;
      end
      if (srv_m && !srv_found) begin
        srv_found <= 1'b1;
        srv_idx   <= rd_idx;
      end
    end
    if (state == ctf_pkg::S_PICK) begin
      tgt <= pick_idx;
      hit <= pick_hit;
    end
  end

endmodule
`default_nettype wire
